// ===== design/assert_macros.svh =====
// Assertion macros for the RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/l2ih_pkg.sv =====
// Types and constants for the log2 interval histogram.
// No dependencies.
`timescale 1ns / 1ps

package l2ih_pkg;

    localparam int CMD_W    = 2;
    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int BNUM_W   = 5;
    localparam int BCNT_W   = 32;
    // seconds * 1e6 + microseconds always fits in 52 bits
    localparam int TIME_W   = 52;
    localparam int LEN_W    = $clog2(TIME_W + 1);

    localparam logic [USEC_W-1:0] US_PER_SECOND = USEC_W'(1000000);

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIFF,
        ST_LEN,
        ST_RD,
        ST_WR,
        ST_CLEAR,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic sum;
        logic diff;
        logic shift;
        logic bin_rd;
        logic bin_wr;
        logic clr;
        logic dump_start;
        logic dump_rd;
        logic dump_next;
    } ctl_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic diff_zero;
        logic dump_last;
    } dp_status_t;

endpackage

// ===== design/l2ih_ctrl.sv =====
// Controller state machine for the log2 interval histogram.
// Uses l2ih_pkg; drives the datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module l2ih_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [l2ih_pkg::CMD_W-1:0]   command,
    input  logic                         out_stall,
    input  l2ih_pkg::dp_status_t         status,
    output logic                         in_stall,
    output logic                         out_valid,
    output l2ih_pkg::ctl_cmd_t           cmd
);
    import l2ih_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_SAMPLE: state_next = ST_MUL;
                        CMD_DUMP:   state_next = ST_DUMP_RD;
                        CMD_CLEAR:  state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIFF;
            // first sample after reset or clear only primes the stored time
            ST_DIFF:  state_next = status.have_prev ? ST_LEN : ST_IDLE;
            ST_LEN:   state_next = status.diff_zero ? ST_RD : ST_LEN;
            ST_RD:    state_next = ST_WR;
            ST_WR:    state_next = ST_IDLE;
            ST_CLEAR: state_next = ST_IDLE;
            ST_DUMP_RD: state_next = ST_DUMP_OUT;
            ST_DUMP_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = status.dump_last ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load_in    = accept && (command == CMD_SAMPLE);
        cmd.dump_start = accept && (command == CMD_DUMP);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.sum        = (state_reg == ST_SUM);
        cmd.diff       = (state_reg == ST_DIFF);
        cmd.shift      = (state_reg == ST_LEN) && !status.diff_zero;
        cmd.bin_rd     = (state_reg == ST_RD);
        cmd.bin_wr     = (state_reg == ST_WR);
        cmd.clr        = (state_reg == ST_CLEAR);
        cmd.dump_rd    = (state_reg == ST_DUMP_RD);
        cmd.dump_next  = (state_reg == ST_DUMP_OUT) && !out_stall;
        in_stall       = (state_reg != ST_IDLE);
        out_valid      = (state_reg == ST_DUMP_OUT);
    end

endmodule

// ===== design/l2ih_datapath.sv =====
// Datapath for the log2 interval histogram: time arithmetic, bit length
// counter and the bin memory. Uses l2ih_pkg; commanded by l2ih_ctrl.
`timescale 1ns / 1ps

module l2ih_datapath #(
    parameter int BIN_COUNT   = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  l2ih_pkg::ctl_cmd_t            cmd,
    input  logic [l2ih_pkg::SEC_W-1:0]    stamp_seconds,
    input  logic [l2ih_pkg::USEC_W-1:0]   stamp_microseconds,
    output l2ih_pkg::dp_status_t          status,
    output logic [l2ih_pkg::BNUM_W-1:0]   bin_number,
    output logic [l2ih_pkg::BCNT_W-1:0]   bin_count,
    output logic                          last_bin
);
    import l2ih_pkg::*;

    localparam int IDX_W   = $clog2(BIN_COUNT);
    localparam int BIN_MAX = BIN_COUNT - 1;

    logic [SEC_W-1:0]       sec_reg;
    logic [USEC_W-1:0]      usec_reg;
    logic [TIME_W-1:0]      prod_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [TIME_W-1:0]      prev_reg;
    logic [TIME_W-1:0]      prev_next;
    logic [TIME_W-1:0]      diff_reg;
    logic [TIME_W-1:0]      diff_next;
    logic                   have_prev_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [IDX_W-1:0]       bin_sat;
    logic [IDX_W-1:0]       bin_addr_reg;
    logic [IDX_W-1:0]       dump_idx_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [BIN_COUNT-1:0]   valid_reg;
    logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   rvalid_reg;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                   rd_en;

    // backward timestamps give a zero interval, which lands in bin 0
    assign diff_next = (now_reg >= prev_reg) ? (now_reg - prev_reg) : '0;
    assign prev_next = now_reg;
    assign len_next  = len_reg + LEN_W'(1);

    assign bin_sat = (int'(len_reg) > BIN_MAX) ? IDX_W'(BIN_MAX) : IDX_W'(len_reg);
    assign rd_en   = cmd.bin_rd || cmd.dump_rd;
    assign rd_addr = cmd.bin_rd ? bin_sat : dump_idx_reg;

    // entries not written since reset or clear read as zero
    assign cur_count = rvalid_reg ? rdata_reg : '0;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            valid_reg     <= '0;
            len_reg       <= '0;
            dump_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                have_prev_reg <= 1'b0;
                valid_reg     <= '0;
            end
            else
            begin
                if (cmd.diff)
                begin
                    have_prev_reg <= 1'b1;
                end
                if (cmd.bin_wr)
                begin
                    valid_reg[bin_addr_reg] <= 1'b1;
                end
            end
            if (cmd.diff)
            begin
                len_reg <= '0;
            end
            else if (cmd.shift)
            begin
                len_reg <= len_next;
            end
            if (cmd.dump_start)
            begin
                dump_idx_reg <= '0;
            end
            else if (cmd.dump_next)
            begin
                dump_idx_reg <= dump_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sec_reg  <= stamp_seconds;
            usec_reg <= stamp_microseconds;
        end
        if (cmd.mul)
        begin
            prod_reg <= TIME_W'(sec_reg) * TIME_W'(US_PER_SECOND);
        end
        if (cmd.sum)
        begin
            now_reg <= prod_reg + TIME_W'(usec_reg);
        end
        if (cmd.clr)
        begin
            prev_reg <= '0;
        end
        else if (cmd.diff)
        begin
            prev_reg <= prev_next;
        end
        if (cmd.diff)
        begin
            diff_reg <= diff_next;
        end
        else if (cmd.shift)
        begin
            diff_reg <= diff_reg >> 1;
        end
        if (cmd.bin_rd)
        begin
            bin_addr_reg <= bin_sat;
        end
    end

    // bin memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.bin_wr)
        begin
            mem[bin_addr_reg] <= inc_count;
        end
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_addr];
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    assign status.have_prev = have_prev_reg;
    assign status.diff_zero = (diff_reg == '0);
    assign status.dump_last = (dump_idx_reg == IDX_W'(BIN_MAX));

    assign bin_number = BNUM_W'(dump_idx_reg);
    assign bin_count  = BCNT_W'(cur_count);
    assign last_bin   = status.dump_last;

endmodule

// ===== design/log2_interval_histogram.sv =====
// Histogram of log2 of the interval between successive timestamps.
// Channels: one input word per command (command, stamp_seconds,
// stamp_microseconds) on in_valid/in_stall; one output word per bin
// (bin_number, bin_count, last_bin) on out_valid/out_stall.
// A sample word runs a 32x20 multiply, an add and a subtract; then a
// one-bit-per-cycle shift counter finds L, the bit length of the interval
// (up to 52), then a read and a write of the bin memory.
// The first sample after reset or clear only stores the time. A clear
// word drops all bins at once through per-bin valid flags. A dump word
// reads each bin in a read state and presents it in an output state, the
// first after acceptance and each further one after the previous is taken;
// in_stall stays high until the last bin is taken.
// A stalled output word holds; the dump simply waits.
// Reset empties every bin and forgets the previous timestamp; no clearing
// pass is needed. Depends on l2ih_pkg, l2ih_ctrl, l2ih_datapath, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module log2_interval_histogram #(
    parameter int BIN_COUNT   = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [l2ih_pkg::CMD_W-1:0]    command,
    input  logic [l2ih_pkg::SEC_W-1:0]    stamp_seconds,
    input  logic [l2ih_pkg::USEC_W-1:0]   stamp_microseconds,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [l2ih_pkg::BNUM_W-1:0]   bin_number,
    output logic [l2ih_pkg::BCNT_W-1:0]   bin_count,
    output logic                          last_bin
);
    import l2ih_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    l2ih_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    l2ih_datapath #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stamp_seconds      (stamp_seconds),
        .stamp_microseconds (stamp_microseconds),
        .status             (status),
        .bin_number         (bin_number),
        .bin_count          (bin_count),
        .last_bin           (last_bin)
    );

    `ASSERT_IMPLY(a_dump_first, clk, rst_n, in_valid && !in_stall && command == CMD_DUMP, ##2 out_valid)
    `ASSERT_IMPLY(a_no_accept_in_dump, clk, rst_n, out_valid, in_stall)
    `ASSERT_NEXT(a_last_ends_dump, clk, rst_n, out_valid && !out_stall && last_bin, !out_valid)
    `ASSERT_NEXT(a_bins_in_order, clk, rst_n, out_valid && !out_stall && !last_bin, ##1 (out_valid && bin_number == $past(bin_number, 2) + 5'd1))

endmodule
